[rtl/tccw_pkg.sv]
// Shared constants and types for the text console cursor writer.
package tccw_pkg;

	localparam logic [7:0] COLUMNS  = 8'd80;
	localparam logic [7:0] ROWS     = 8'd30;
	localparam logic [7:0] ROW_LAST = ROWS - 8'd1;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_BLINK = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_SET   = 2'd3;

	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_SCROLL = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	localparam logic [2:0] TAB_WIDTH = 3'd4;

	localparam logic [1:0] REG_GLYPH  = 2'd0;
	localparam logic [1:0] REG_SHOW   = 2'd1;
	localparam logic [1:0] REG_PERIOD = 2'd2;

	localparam logic [7:0] GLYPH_RST  = 8'd219;
	localparam logic [6:0] SHOW_RST   = 7'd32;
	localparam logic [6:0] PERIOD_RST = 7'd64;

	typedef struct packed {
		logic [1:0] cmd;
		logic [4:0] row;
		logic [6:0] col;
		logic [7:0] data;
		logic       last;
		logic [4:0] cur_row;
		logic [6:0] cur_col;
	} res_t;

endpackage

[rtl/text_console_cursor_writer_top.sv]
// Text console cursor writer: cursor tracking, blink and screen memory commands.
//
// Each request is taken into an input register; once the result queue is free,
// its memory commands (write cell, scroll, clear; up to three) are loaded into
// a small result queue and leave one per cycle while out_ready is high. A request
// that gives one command or none runs at one per cycle while out_ready is high;
// a request with more commands holds the output side until they have drained,
// as only one command leaves per cycle. The first command is presented once the
// request has passed the input register and been loaded into the result queue.
// The input register holds one further request while results drain.
module text_console_cursor_writer_top
	import tccw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  logic [7:0] char_in,
	input  logic [7:0] cell_now,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] command,
	output logic [4:0] row,
	output logic [6:0] col,
	output logic [7:0] data,
	output logic       last,
	output logic [4:0] cur_row,
	output logic [6:0] cur_col
);

	logic [7:0] glyph_q;
	logic [6:0] show_q;
	logic [6:0] period_q;

	logic [4:0] row_q;
	logic [6:0] col_q;
	logic [6:0] blink_q;
	logic [7:0] saved_q;
	logic       shown_q;

	logic       valid_s1;
	logic [1:0] op_s1;
	logic [7:0] ch_s1;
	logic [7:0] cell_s1;

	res_t       res_q [3];
	logic [1:0] out_cnt_q;

	logic       out_take;
	logic       buf_free;
	logic       s1_fire;

	// next-state and command list
	logic       e_r, e_w, e_x;
	logic [1:0] x_cmd;
	logic [7:0] w_data;
	logic [4:0] x_row, f_row;
	logic [6:0] x_col, f_col;
	logic [4:0] n_row;
	logic [6:0] n_col;
	logic [6:0] n_blink;
	logic [7:0] n_saved;
	logic       n_shown;
	logic       is_wr, is_tab, nl, sc;
	logic [2:0] step;
	logic [7:0] nc;
	logic [6:0] bc;
	res_t       slot [3];
	logic [1:0] k;

	assign out_take = out_valid && out_ready;
	assign buf_free = (out_cnt_q == 2'd0) || (out_cnt_q == 2'd1 && out_ready);
	assign s1_fire  = valid_s1 && buf_free;
	assign in_ready = !valid_s1 || s1_fire;

	always_comb begin
		e_r     = 1'b0;
		e_w     = 1'b0;
		e_x     = 1'b0;
		x_cmd   = CMD_SCROLL;
		w_data  = ch_s1;
		x_row   = row_q;
		x_col   = 7'd0;
		f_row   = row_q;
		f_col   = col_q;
		n_blink = blink_q;
		n_saved = saved_q;
		n_shown = shown_q;
		is_wr   = 1'b0;
		is_tab  = 1'b0;
		nl      = 1'b0;
		sc      = 1'b0;
		step    = 3'd0;
		nc      = {1'b0, col_q};
		bc      = blink_q + 7'd1;

		case (op_s1)
			OP_PUT: begin
				e_r     = shown_q;
				n_blink = 7'd0;
				n_shown = 1'b0;
				is_tab  = (ch_s1 == CH_TAB);
				is_wr   = (ch_s1 != CH_NUL) && (ch_s1 != CH_LF) && (ch_s1 != CH_CR) && !is_tab;
				e_w     = is_wr;
				if (is_wr)
					step = 3'd1;
				else if (is_tab)
					step = TAB_WIDTH - {1'b0, col_q[1:0]};
				nc = {1'b0, col_q} + {5'd0, step};
				nl = (ch_s1 == CH_LF) || ((is_wr || is_tab) && nc >= COLUMNS);
				sc = nl && ({3'd0, row_q} >= ROW_LAST);
				e_x = sc;
				if (ch_s1 == CH_CR) begin
					f_col = 7'd0;
				end else if (nl) begin
					f_col = 7'd0;
					f_row = sc ? row_q : row_q + 5'd1;
				end else begin
					f_col = nc[6:0];
				end
			end
			OP_BLINK: begin
				n_blink = bc;
				if (bc == show_q) begin
					n_saved = cell_s1;
					e_w     = 1'b1;
					w_data  = glyph_q;
					n_shown = 1'b1;
				end else if (bc == period_q) begin
					n_blink = 7'd0;
					e_r     = shown_q;
					n_shown = 1'b0;
				end
			end
			OP_CLEAR: begin
				e_r     = shown_q;
				e_x     = 1'b1;
				x_cmd   = CMD_CLEAR;
				x_row   = 5'd0;
				f_row   = 5'd0;
				f_col   = 7'd0;
				n_blink = 7'd0;
				n_shown = 1'b0;
			end
			default: begin
				e_w     = 1'b1;
				n_saved = ch_s1;
			end
		endcase

		n_row = f_row;
		n_col = f_col;

		for (int i = 0; i < 3; i++)
			slot[i] = '0;
		k = 2'd0;
		if (e_r) begin
			slot[k].cmd  = CMD_WRITE;
			slot[k].row  = row_q;
			slot[k].col  = col_q;
			slot[k].data = saved_q;
			slot[k].last = !e_w && !e_x;
			if (e_w) begin
				slot[k].cur_row = row_q;
				slot[k].cur_col = col_q;
			end else if (e_x) begin
				slot[k].cur_row = x_row;
				slot[k].cur_col = x_col;
			end else begin
				slot[k].cur_row = f_row;
				slot[k].cur_col = f_col;
			end
			k = k + 2'd1;
		end
		if (e_w) begin
			slot[k].cmd     = CMD_WRITE;
			slot[k].row     = row_q;
			slot[k].col     = col_q;
			slot[k].data    = w_data;
			slot[k].last    = !e_x;
			slot[k].cur_row = e_x ? x_row : f_row;
			slot[k].cur_col = e_x ? x_col : f_col;
			k = k + 2'd1;
		end
		if (e_x) begin
			slot[k].cmd     = x_cmd;
			slot[k].last    = 1'b1;
			slot[k].cur_row = f_row;
			slot[k].cur_col = f_col;
			k = k + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_q  <= GLYPH_RST;
			show_q   <= SHOW_RST;
			period_q <= PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GLYPH:  glyph_q  <= cfg_wdata;
				REG_SHOW:   show_q   <= cfg_wdata[6:0];
				REG_PERIOD: period_q <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= opcode;
			ch_s1   <= char_in;
			cell_s1 <= cell_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= 5'd0;
			col_q   <= 7'd0;
			blink_q <= 7'd0;
			saved_q <= 8'd0;
			shown_q <= 1'b0;
		end else if (s1_fire) begin
			row_q   <= n_row;
			col_q   <= n_col;
			blink_q <= n_blink;
			saved_q <= n_saved;
			shown_q <= n_shown;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= 2'd0;
		end else if (s1_fire) begin
			out_cnt_q <= k;
		end else if (out_take) begin
			out_cnt_q <= out_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			res_q[0] <= slot[0];
			res_q[1] <= slot[1];
			res_q[2] <= slot[2];
		end else if (out_take) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

	assign out_valid = (out_cnt_q != 2'd0);
	assign command   = res_q[0].cmd;
	assign row       = res_q[0].row;
	assign col       = res_q[0].col;
	assign data      = res_q[0].data;
	assign last      = res_q[0].last;
	assign cur_row   = res_q[0].cur_row;
	assign cur_col   = res_q[0].cur_col;

	a_fire_free: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |-> (out_cnt_q == 2'd0 || (out_cnt_q == 2'd1 && out_ready)))
		else $error("request moved on while results pending");

	a_last_tail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (out_cnt_q == 2'd1)))
		else $error("last flag out of step with queue");

	a_clear_home: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && op_s1 == OP_CLEAR) |=> (row_q == 5'd0 && col_q == 7'd0))
		else $error("cursor not homed after clear");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, col_q} < COLUMNS) && ({3'd0, row_q} < ROWS))
		else $error("cursor off screen");

endmodule
